[hw/rtl/psnr_acc_pkg.sv]
// ----------------------------------------------------------------------------
// psnr_acc_pkg
// Shared constants, types and the log table generator of the PSNR accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package psnr_acc_pkg;

  // default configuration
  localparam int unsigned MAX_PIXELS_LOG2_DEF = 22;
  localparam int unsigned LOG_TABLE_BITS_DEF  = 6;
  localparam int unsigned JOB_DEPTH_DEF       = 4;
  // a job holds its result slot from issue until it is popped, so a depth above the jobs in flight keeps full rate
  localparam int unsigned OUT_DEPTH_DEF       = 12;

  // register stages inside one log2 unit
  localparam int unsigned LOG_LAT = 4;

  localparam int unsigned PSNR_W = 15;
  localparam int unsigned RES_W  = PSNR_W + 1;

  localparam logic [PSNR_W-1:0] OUT_MAX         = 15'h7fff;
  // 10*log10(2) in Q.16
  localparam logic [17:0]       DB_PER_LOG2_Q16 = 18'd197283;
  // 20*log10(255) in Q.32
  localparam logic [37:0]       PEAK_DB_Q32     = 38'(64'd3154300 << 16);

  typedef struct packed {
    logic full;
    logic empty;
  } q_flags_t;

  // round(65536*log2(1+i/2^tbits)), exact by repeated squaring to 20 bits
  function automatic logic [16:0] log_entry(int unsigned i, int unsigned tbits);
    logic [63:0] m;
    logic [19:0] r;
    logic [20:0] rr;
    m = (64'd1 << 30) + (64'(i) << (30 - tbits));
    r = '0;
    for (int b = 19; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m    = m >> 1;
        r[b] = 1'b1;
      end
    end
    rr = {1'b0, r} + 21'd8;
    if (i >= (32'd1 << tbits)) begin
      return 17'h10000;
    end
    return 17'(rr >> 4);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/psnr_acc_fifo.sv]
// ----------------------------------------------------------------------------
// psnr_acc_fifo
// Small register queue with occupancy count, used for jobs and for results.
// ----------------------------------------------------------------------------
`default_nettype none

module psnr_acc_fifo import psnr_acc_pkg::*; #(
  parameter int unsigned W     = 16,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNTW = $clog2(DEPTH + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire logic [W-1:0]    data_i,
  input  wire logic            pop_i,
  output      logic [W-1:0]    data_o,
  output      q_flags_t        flags_o,
  output      logic [CNTW-1:0] count_o
);

  logic [W-1:0]    mem_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0] cnt_q;
  logic            wr, rd;

  assign flags_o.full  = (cnt_q == CNTW'(DEPTH));
  assign flags_o.empty = (cnt_q == '0);
  assign wr      = push_i && !flags_o.full;
  assign rd      = pop_i && !flags_o.empty;
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr && !rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd && !wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/psnr_acc_log2.sv]
// ----------------------------------------------------------------------------
// psnr_acc_log2
// Pipelined base-2 logarithm in Q.16: leading-one search, table, interpolation.
// ----------------------------------------------------------------------------
`default_nettype none

module psnr_acc_log2 import psnr_acc_pkg::*; #(
  parameter int unsigned W              = 38,
  parameter int unsigned LOG_TABLE_BITS = LOG_TABLE_BITS_DEF,
  localparam int unsigned PW = $clog2(W),
  localparam int unsigned LW = PW + 17
) (
  input  wire logic          clk_i,
  input  wire logic [W-1:0]  x_i,
  output      logic [LW-1:0] y_o
);

  localparam int unsigned T   = LOG_TABLE_BITS;
  localparam int unsigned TS  = 1 << T;
  localparam int unsigned NC  = (W + 7) / 8;
  localparam int unsigned XW  = NC * 8;
  localparam int unsigned RW  = 31 - T;
  localparam int unsigned FW  = (W > 32) ? W : 32;

  logic [16:0] tbl [TS+1];

  for (genvar g = 0; g <= TS; g++) begin : g_tbl
    localparam logic [16:0] ENTRY = log_entry(g, T);
    assign tbl[g] = ENTRY;
  end

  // stage a: per-byte leading one
  logic [XW-1:0] xpad;
  logic [NC-1:0] nz_d, nz_q;
  logic [2:0]    pos_d [NC];
  logic [2:0]    pos_q [NC];
  logic [XW-1:0] xa_q;

  assign xpad = XW'(x_i);

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      nz_d[c]  = |xpad[c*8 +: 8];
      pos_d[c] = '0;
      for (int b = 0; b < 8; b++) begin
        if (xpad[c*8 + b]) begin
          pos_d[c] = 3'(b);
        end
      end
    end
  end

  // stage b: pick the top non-zero byte
  logic [PW-1:0] pb_d, pb_q;
  logic [W-1:0]  xb_q;

  always_comb begin
    pb_d = '0;
    for (int c = 0; c < NC; c++) begin
      if (nz_q[c]) begin
        pb_d = PW'(c * 8) + PW'(pos_q[c]);
      end
    end
  end

  // stage c: normalise and look up the table
  logic [PW-1:0] sh;
  logic [W-1:0]  n;
  logic [FW-1:0] nf;
  logic [31:0]   f;
  logic [T-1:0]  idx;
  logic [T:0]    ilo, ihi;
  logic [16:0]   lo, hi;
  logic [PW-1:0] pc_q;
  logic [16:0]   lo_q, dl_q;
  logic [RW-1:0] r_q;

  assign sh  = PW'(W - 1) - pb_q;
  assign n   = xb_q << sh;
  assign nf  = FW'(n) << (FW - W);
  assign f   = nf[FW-1 -: 32];
  assign idx = f[30 -: T];
  assign ilo = {1'b0, idx};
  assign ihi = ilo + (T+1)'(1);
  assign lo  = tbl[ilo];
  assign hi  = tbl[ihi];

  // stage d: interpolate
  logic [16+RW:0] prod;
  logic [LW-1:0]  y_d, y_q;

  assign prod = (17+RW)'(dl_q) * (17+RW)'(r_q);
  assign y_d  = LW'({pc_q, 16'h0000}) + LW'(lo_q) + LW'(prod >> RW);

  always_ff @(posedge clk_i) begin
    xa_q  <= xpad;
    nz_q  <= nz_d;
    pos_q <= pos_d;
    pb_q  <= pb_d;
    xb_q  <= xa_q[W-1:0];
    pc_q  <= pb_q;
    lo_q  <= lo;
    dl_q  <= hi - lo;
    r_q   <= f[RW-1:0];
    y_q   <= y_d;
  end

  assign y_o = y_q;

endmodule

`default_nettype wire

[hw/rtl/psnr_acc_front.sv]
// ----------------------------------------------------------------------------
// psnr_acc_front
// Squared-error and pair accumulation; hands a job to the back on the last pair.
// ----------------------------------------------------------------------------
`default_nettype none

module psnr_acc_front import psnr_acc_pkg::*; #(
  parameter int unsigned MAX_PIXELS_LOG2 = MAX_PIXELS_LOG2_DEF,
  localparam int unsigned SW = MAX_PIXELS_LOG2 + 16,
  localparam int unsigned CW = MAX_PIXELS_LOG2 + 1,
  localparam int unsigned JW = SW + CW + 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    pixel_a_i,
  input  wire logic [7:0]    pixel_b_i,
  input  wire logic          last_pixel_i,
  output      logic          job_push_o,
  output      logic [JW-1:0] job_o
);

  logic signed [8:0]  diff;
  logic signed [17:0] sq_full;
  logic [15:0]        sq;
  logic [SW:0]        sum_ext;
  logic [SW-1:0]      sum_d, sum_q;
  logic [CW-1:0]      cnt_d, cnt_q;
  logic               ident;

  assign diff    = $signed({1'b0, pixel_a_i}) - $signed({1'b0, pixel_b_i});
  assign sq_full = 18'(diff) * 18'(diff);
  assign sq      = sq_full[15:0];
  assign sum_ext = {1'b0, sum_q} + (SW+1)'(sq);
  // both counters saturate
  assign sum_d   = sum_ext[SW] ? '1 : sum_ext[SW-1:0];
  assign cnt_d   = cnt_q[CW-1] ? cnt_q : cnt_q + 1'b1;
  assign ident   = (sum_d == '0);

  assign job_push_o = accept_i && last_pixel_i;
  assign job_o      = {ident, sum_d, cnt_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else if (accept_i) begin
      if (last_pixel_i) begin
        sum_q <= '0;
        cnt_q <= '0;
      end else begin
        sum_q <= sum_d;
        cnt_q <= cnt_d;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/psnr_acc_back.sv]
// ----------------------------------------------------------------------------
// psnr_acc_back
// Log pipeline turning a sum and count into PSNR, with a credited result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module psnr_acc_back import psnr_acc_pkg::*; #(
  parameter int unsigned MAX_PIXELS_LOG2 = MAX_PIXELS_LOG2_DEF,
  parameter int unsigned LOG_TABLE_BITS  = LOG_TABLE_BITS_DEF,
  parameter int unsigned OUT_DEPTH       = OUT_DEPTH_DEF,
  localparam int unsigned SW = MAX_PIXELS_LOG2 + 16,
  localparam int unsigned CW = MAX_PIXELS_LOG2 + 1,
  localparam int unsigned JW = SW + CW + 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              job_valid_i,
  input  wire logic [JW-1:0]     job_i,
  output      logic              job_pop_o,
  input  wire logic              pop_i,
  output      logic              empty_o,
  output      logic [PSNR_W-1:0] psnr_db_q8_o,
  output      logic              identical_o
);

  localparam int unsigned NS    = LOG_LAT + 3;
  localparam int unsigned ST_E  = LOG_LAT + 1;
  localparam int unsigned ST_F  = LOG_LAT + 2;
  localparam int unsigned LW    = $clog2(SW) + 17;
  localparam int unsigned LWC   = $clog2(CW) + 17;
  localparam int unsigned VW    = LW + 19;
  localparam int unsigned RNDW  = VW - 24;
  localparam int unsigned OCW   = $clog2(OUT_DEPTH + 1);

  logic [NS-1:0]     v_q;
  logic [NS-1:0]     id_q;
  logic [SW-1:0]     sum0_q;
  logic [CW-1:0]     cnt0_q;
  logic [OCW-1:0]    occ;
  q_flags_t          oflags;
  logic [RES_W-1:0]  res_data;
  logic              issue;

  // a slot in the result queue is reserved for every job in flight
  assign issue     = job_valid_i && ((int'(occ) + $countones(v_q)) < int'(OUT_DEPTH));
  assign job_pop_o = issue;

  logic [LW-1:0]  ls;
  logic [LWC-1:0] lc_n;
  logic [LW-1:0]  lc;

  psnr_acc_log2 #(
    .W              (SW),
    .LOG_TABLE_BITS (LOG_TABLE_BITS)
  ) u_log_sum (
    .clk_i (clk_i),
    .x_i   (sum0_q),
    .y_o   (ls)
  );

  psnr_acc_log2 #(
    .W              (CW),
    .LOG_TABLE_BITS (LOG_TABLE_BITS)
  ) u_log_cnt (
    .clk_i (clk_i),
    .x_i   (cnt0_q),
    .y_o   (lc_n)
  );

  assign lc = LW'(lc_n);

  // stage e: scale the log ratio to decibels
  logic [LW-1:0]    mag;
  logic             neg_d, neg_q;
  logic [LW+17:0]   term_q;

  assign neg_d = (lc < ls);
  assign mag   = neg_d ? (ls - lc) : (lc - ls);

  // stage f: add the peak term, round to Q.8 and clamp
  logic [VW-1:0]     base, term_w, sum_f;
  logic [RNDW-1:0]   rnd;
  logic [PSNR_W-1:0] psnr_d, psnr_q;

  assign base   = VW'(PEAK_DB_Q32);
  assign term_w = VW'(term_q);

  always_comb begin
    if (!neg_q) begin
      sum_f = base + term_w;
    end else if (term_w >= base) begin
      sum_f = '0;
    end else begin
      sum_f = base - term_w;
    end
    rnd = RNDW'((sum_f + VW'(32'd1 << 23)) >> 24);
    if (id_q[ST_E]) begin
      psnr_d = OUT_MAX;
    end else if (rnd > RNDW'(OUT_MAX)) begin
      psnr_d = OUT_MAX;
    end else begin
      psnr_d = rnd[PSNR_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      sum0_q <= job_i[SW+CW-1:CW];
      cnt0_q <= job_i[CW-1:0];
    end
    id_q   <= {id_q[NS-2:0], job_i[JW-1]};
    neg_q  <= neg_d;
    term_q <= (LW+18)'(mag) * (LW+18)'(DB_PER_LOG2_Q16);
    psnr_q <= psnr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[NS-2:0], issue};
    end
  end

  psnr_acc_fifo #(
    .W     (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (v_q[ST_F]),
    .data_i  ({psnr_q, id_q[ST_F]}),
    .pop_i   (pop_i),
    .data_o  (res_data),
    .flags_o (oflags),
    .count_o (occ)
  );

  assign empty_o      = oflags.empty;
  assign psnr_db_q8_o = res_data[RES_W-1:1];
  assign identical_o  = res_data[0];

endmodule

`default_nettype wire

[hw/rtl/psnr_component_accumulator_unit.sv]
// ----------------------------------------------------------------------------
// psnr_component_accumulator_unit
// PSNR of one 8-bit colour plane from a stream of co-located pixel pairs.
// ----------------------------------------------------------------------------
// One pixel pair is taken every clock cycle while full is low. The front
// squares the difference and accumulates sum and pair count in the same
// cycle; the pair marked last closes the plane and drops a job into a small
// job queue. The back is a fully pipelined log unit (leading-one search,
// table with linear interpolation, decibel scaling), so a plane may be as
// short as one pair and the block still runs at one pair per cycle while
// full is low. A result passes the job queue write on the edge that takes
// its last pair, the seven back stages and the result queue write.
// The back only starts a job when a result queue slot is reserved for it, so
// a stalled reader backs up into the job queue and then raises full. An error
// sum of zero gives identical set and the PSNR saturated to its maximum.
// ----------------------------------------------------------------------------
`default_nettype none

module psnr_component_accumulator_unit import psnr_acc_pkg::*; #(
  parameter int unsigned MAX_PIXELS_LOG2 = MAX_PIXELS_LOG2_DEF,
  parameter int unsigned LOG_TABLE_BITS  = LOG_TABLE_BITS_DEF,
  parameter int unsigned JOB_DEPTH       = JOB_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH       = OUT_DEPTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output      logic              full,
  input  wire logic [7:0]        pixel_a_i,
  input  wire logic [7:0]        pixel_b_i,
  input  wire logic              last_pixel_i,
  output      logic              empty,
  input  wire logic              pop,
  output      logic [PSNR_W-1:0] psnr_db_q8_o,
  output      logic              identical_o
);

  localparam int unsigned SW  = MAX_PIXELS_LOG2 + 16;
  localparam int unsigned CW  = MAX_PIXELS_LOG2 + 1;
  localparam int unsigned JW  = SW + CW + 1;
  localparam int unsigned JCW = $clog2(JOB_DEPTH + 1);

  logic           accept;
  logic           job_push, job_pop;
  logic [JW-1:0]  job_in, job_out;
  q_flags_t       jflags;
  logic [JCW-1:0] jcount;

  assign accept = push && !full;
  assign full   = jflags.full;

  psnr_acc_front #(
    .MAX_PIXELS_LOG2 (MAX_PIXELS_LOG2)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .pixel_a_i    (pixel_a_i),
    .pixel_b_i    (pixel_b_i),
    .last_pixel_i (last_pixel_i),
    .job_push_o   (job_push),
    .job_o        (job_in)
  );

  psnr_acc_fifo #(
    .W     (JW),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .flags_o (jflags),
    .count_o (jcount)
  );

  psnr_acc_back #(
    .MAX_PIXELS_LOG2 (MAX_PIXELS_LOG2),
    .LOG_TABLE_BITS  (LOG_TABLE_BITS),
    .OUT_DEPTH       (OUT_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (!jflags.empty),
    .job_i        (job_out),
    .job_pop_o    (job_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .psnr_db_q8_o (psnr_db_q8_o),
    .identical_o  (identical_o)
  );

  // a closed plane is waiting in the job queue on the next cycle
  a_job_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_pixel_i |=> !jflags.empty)
    else $error("closed plane did not reach the job queue");

  // the back never takes a job from an empty queue
  a_no_phantom_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> !jflags.empty && (jcount != '0))
    else $error("job taken from empty queue");

  // an identical plane always reports the saturated value
  a_identical_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && identical_o |-> psnr_db_q8_o == OUT_MAX)
    else $error("identical result without saturated psnr");

  // full only rises after a plane was closed
  a_full_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(job_push))
    else $error("job queue filled without a closed plane");

endmodule

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams planes of pixel pairs into the PSNR accumulator and checks each
// result against a fixed-point prediction of the plane's PSNR, with random
// idle gaps on the pixel side and random stalls on the result side.
// ----------------------------------------------------------------------------

module testbench;
  import psnr_acc_pkg::*;

  localparam int unsigned HALF_PERIOD  = 5;
  localparam int unsigned RESET_CYCLES = 4;
  localparam int unsigned ITEM_TARGET  = 1250;
  localparam int unsigned MAX_GAP      = 18;
  localparam int unsigned DRAIN_CYCLES = 30;
  localparam int unsigned STALL_LIMIT  = 2000;

  localparam int unsigned     CNT_LOG2    = MAX_PIXELS_LOG2_DEF;
  localparam int unsigned     TBL_BITS    = LOG_TABLE_BITS_DEF;
  localparam int unsigned     TBL_N       = 1 << TBL_BITS;
  localparam longint unsigned COUNT_CAP   = 64'd1 << CNT_LOG2;
  localparam longint unsigned SUM_CAP     = (64'd1 << (CNT_LOG2 + 16)) - 1;
  localparam longint unsigned DB_STEP_Q16 = 197283;
  localparam longint unsigned PEAK_Q16    = 3154300;
  localparam logic [PSNR_W-1:0] PSNR_SAT  = '1;

  typedef struct packed {
    logic [PSNR_W-1:0] db;
    logic              ident;
  } psnr_res_t;

  typedef enum int unsigned {
    PIX_SAME,
    PIX_NEAR,
    PIX_ANY,
    PIX_WORST,
    PIX_ONE_OFF
  } pix_mode_e;

  class psnr_tracker;
    bit [CNT_LOG2+16:0] err_sum;
    bit [CNT_LOG2:0]    pair_cnt;
    bit [16:0]          log_frac [TBL_N+1];
    psnr_res_t          psnr_due [$];
    int unsigned        errors;

    function new();
      for (int i = 0; i <= TBL_N; i++) begin
        log_frac[i] = frac_entry(i);
      end
    endfunction

    // fraction of log2(1 + i/TBL_N) in Q.16, squared out to 20 bits then rounded
    function bit [16:0] frac_entry(int unsigned i);
      bit [63:0] m;
      bit [19:0] r;
      if (i >= TBL_N) begin
        return 17'h10000;
      end
      m = (64'd1 << 30) + (64'(i) << (30 - TBL_BITS));
      r = '0;
      for (int k = 19; k >= 0; k--) begin
        m = (m * m) >> 30;
        if (m >= (64'd2 << 30)) begin
          m    = m >> 1;
          r[k] = 1'b1;
        end
      end
      return 17'((21'(r) + 21'd8) >> 4);
    endfunction

    function bit [63:0] log2_q16(bit [63:0] x);
      int unsigned p;
      bit [63:0]   t, f, idx, rem, lo, hi;
      p = 0;
      t = x;
      while (t > 1) begin
        t = t >> 1;
        p++;
      end
      if (p <= 31) f = x << (31 - p);
      else f = x >> (p - 31);
      idx = (f >> (31 - TBL_BITS)) & (TBL_N - 1);
      rem = f & ((64'd1 << (31 - TBL_BITS)) - 1);
      lo  = log_frac[idx];
      hi  = log_frac[idx+1];
      return (64'(p) << 16) + lo + (((hi - lo) * rem) >> (31 - TBL_BITS));
    endfunction

    function psnr_res_t plane_psnr();
      psnr_res_t res;
      bit [63:0] lc, ls, base, term, v;
      if (err_sum == 0) begin
        res.db    = PSNR_SAT;
        res.ident = 1'b1;
        return res;
      end
      lc   = log2_q16(64'(pair_cnt));
      ls   = log2_q16(64'(err_sum));
      base = PEAK_Q16 << 16;
      if (lc >= ls) begin
        v = base + (lc - ls) * DB_STEP_Q16;
      end else begin
        term = (ls - lc) * DB_STEP_Q16;
        v    = (term >= base) ? 64'd0 : base - term;
      end
      v = (v + (64'd1 << 23)) >> 24;
      if (v > PSNR_SAT) v = PSNR_SAT;
      res.db    = PSNR_W'(v);
      res.ident = 1'b0;
      return res;
    endfunction

    function void take_pair(bit [7:0] a, bit [7:0] b, bit last);
      int        d;
      bit [63:0] acc;
      d   = int'(a) - int'(b);
      acc = 64'(err_sum) + 64'(d * d);
      if (acc > SUM_CAP) acc = SUM_CAP;
      err_sum = acc[CNT_LOG2+16:0];
      if (pair_cnt < COUNT_CAP) pair_cnt++;
      if (last) begin
        psnr_due.push_back(plane_psnr());
        err_sum  = '0;
        pair_cnt = '0;
      end
    endfunction

    function void check_psnr(bit [PSNR_W-1:0] db, bit ident);
      psnr_res_t want;
      if (psnr_due.size() == 0) begin
        $display("%0t: result beat with none pending: psnr_db_q8 %0d identical %0d",
                 $time, db, ident);
        errors++;
        return;
      end
      want = psnr_due.pop_front();
      if (db !== want.db) begin
        $display("%0t: psnr_db_q8 expected %0d got %0d", $time, want.db, db);
        errors++;
      end
      if (ident !== want.ident) begin
        $display("%0t: identical expected %0d got %0d", $time, want.ident, ident);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return psnr_due.size();
    endfunction
  endclass

  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              push       = 1'b0;
  logic              pop        = 1'b0;
  logic [7:0]        pixel_a    = '0;
  logic [7:0]        pixel_b    = '0;
  logic              last_pixel = 1'b0;
  logic              full;
  logic              empty;
  logic [PSNR_W-1:0] psnr_db_q8;
  logic              identical;

  psnr_tracker tracker = new();
  int unsigned sent    = 0;
  bit          tx_calm = 1'b0;
  int unsigned stall_cycles = 0;

  always #(HALF_PERIOD) clk_i = ~clk_i;

  psnr_component_accumulator_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .pixel_a_i    (pixel_a),
    .pixel_b_i    (pixel_b),
    .last_pixel_i (last_pixel),
    .empty        (empty),
    .pop          (pop),
    .psnr_db_q8_o (psnr_db_q8),
    .identical_o  (identical)
  );

  task automatic send_pair(input logic [7:0] a, input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push       <= 1'b1;
    pixel_a    <= a;
    pixel_b    <= b;
    last_pixel <= last;
    do begin
      @(posedge clk_i);
    end while (full);
    tracker.take_pair(a, b, last);
    sent++;
  endtask

  task automatic send_plane(input int unsigned len, input pix_mode_e mode);
    logic [7:0]  a, b;
    int unsigned odd_at;
    int          near;
    odd_at = $urandom_range(0, len - 1);
    for (int unsigned k = 0; k < len; k++) begin
      a = 8'($urandom);
      case (mode)
        PIX_SAME: begin
          b = a;
        end
        PIX_NEAR: begin
          near = int'(a) + int'($urandom_range(0, 6)) - 3;
          if (near < 0) near = 0;
          if (near > 255) near = 255;
          b = 8'(near);
        end
        PIX_ANY: begin
          b = 8'($urandom);
        end
        PIX_WORST: begin
          a = ($urandom_range(0, 1) == 1) ? 8'hff : 8'h00;
          b = ~a;
        end
        default: begin
          b = (k == odd_at) ? (a ^ 8'h01) : a;
        end
      endcase
      send_pair(a, b, k == len - 1);
    end
  endtask

  // hold the pixel side until every plane sent so far has its result back
  task automatic wait_drained();
    push <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  initial begin : result_side
    int unsigned gap;
    int unsigned pops;
    bit          rx_calm;
    pops    = 0;
    rx_calm = 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (pops % 40 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      gap = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do begin
        @(posedge clk_i);
      end while (empty);
      tracker.check_psnr(psnr_db_q8, identical);
      pops++;
    end
  end

  initial begin : pixel_side
    pix_mode_e   mode;
    int unsigned len;
    int unsigned pick;
    bit          paused;
    paused = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // single-pair planes: zero error, then the worst error both ways round; then three-pair planes
    send_pair(8'd0, 8'd0, 1'b1);
    send_pair(8'd255, 8'd0, 1'b1);
    send_pair(8'd0, 8'd255, 1'b1);
    send_pair(8'd0, 8'd0, 1'b0);
    send_pair(8'd255, 8'd255, 1'b0);
    send_pair(8'd128, 8'd128, 1'b1);
    send_pair(8'd0, 8'd1, 1'b0);
    send_pair(8'd7, 8'd7, 1'b0);
    send_pair(8'd200, 8'd200, 1'b1);
    // a plane with all pairs at full difference, result near or below zero dB, then mixed-error planes
    send_pair(8'd255, 8'd0, 1'b0);
    send_pair(8'd0, 8'd255, 1'b0);
    send_pair(8'd255, 8'd0, 1'b1);
    send_pair(8'd170, 8'd85, 1'b0);
    send_pair(8'd85, 8'd170, 1'b1);
    send_pair(8'd1, 8'd2, 1'b0);
    send_pair(8'd254, 8'd253, 1'b0);
    send_pair(8'd100, 8'd90, 1'b0);
    send_pair(8'd15, 8'd240, 1'b1);
    wait_drained();

    while (sent < ITEM_TARGET) begin
      tx_calm = ($urandom_range(0, 2) == 0);
      pick    = $urandom_range(0, 9);
      if (pick < 6) len = $urandom_range(1, 8);
      else if (pick < 9) len = $urandom_range(9, 40);
      else len = $urandom_range(41, 150);
      mode = pix_mode_e'($urandom_range(0, int'(PIX_ONE_OFF)));
      send_plane(len, mode);
      if (!paused && sent >= ITEM_TARGET / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
